// ===== rtl/pali_pkg.sv =====
// Package for the polyline arc-length interpolator: widths, codes and the
// control/status structs shared by the top level and the root/divide unit.
// No dependencies.
package pali_pkg;

    // Field widths
    localparam int COORD_BITS         = 16;
    localparam int PROGRESS_FRAC_BITS = 16;
    localparam int LEN_FRAC_BITS      = 6;

    // Configuration registers: four points, x then y
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    localparam int PROG_W = PROGRESS_FRAC_BITS + 1;
    localparam int F_W    = PROGRESS_FRAC_BITS + 1;

    // Sum of squares, radicand (even width), root and length sums
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int RAD_W   = ((SQ_W + 2 * LEN_FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int LEN_W   = ROOT_W;
    localparam int TOTAL_W = LEN_W + 2;
    localparam int DIST_W  = TOTAL_W + PROGRESS_FRAC_BITS;

    // Root/divide unit widths
    localparam int Q_W   = (ROOT_W > F_W) ? ROOT_W : F_W;
    localparam int NUM_W = (RAD_W > DIST_W) ? RAD_W : DIST_W;
    localparam int CNT_W = $clog2(Q_W);

    // Shared signed multiplier
    localparam int MUL_M1 = (TOTAL_W > PROG_W) ? TOTAL_W : PROG_W;
    localparam int MUL_M2 = (MUL_M1 > COORD_BITS + 1) ? MUL_M1 : COORD_BITS + 1;
    localparam int MW     = MUL_M2 + 1;
    localparam int PROD_W = 2 * MW;

    // Interpolation accumulator
    localparam int VAL_W = COORD_BITS + PROGRESS_FRAC_BITS + 2;

    localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROGRESS_FRAC_BITS;

    // Segment codes
    localparam int SEG_W = 2;
    localparam logic [SEG_W-1:0] SEG0 = 2'd0;
    localparam logic [SEG_W-1:0] SEG1 = 2'd1;
    localparam logic [SEG_W-1:0] SEG2 = 2'd2;

    // Operations of the root/divide unit
    typedef enum logic {
        UOP_SQRT = 1'b0,
        UOP_DIV  = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     go;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] result;
    } unit_stat_t;

endpackage

// ===== rtl/pali_root_div.sv =====
// Iterative root/divide unit: one result bit per cycle through a single
// shared compare-subtract stage. Integer square root or restoring division.
// Depends on pali_pkg.
module pali_root_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pali_pkg::unit_cmd_t               cmd,
    input  logic [pali_pkg::NUM_W-1:0]        num,
    input  logic [pali_pkg::LEN_W-1:0]        den,
    output pali_pkg::unit_stat_t              stat
);

    // Control
    logic                         busy_reg;
    logic                         done_reg;
    pali_pkg::unit_op_t           op_reg;
    logic [pali_pkg::CNT_W-1:0]   cnt_reg;

    // Datapath
    logic [pali_pkg::RAD_W-1:0]   num_reg;
    logic [pali_pkg::DIST_W-1:0]  rem_reg;
    logic [pali_pkg::DIST_W-1:0]  den_reg;
    logic [pali_pkg::Q_W-1:0]     q_reg;

    logic [pali_pkg::DIST_W-1:0]  opa;
    logic [pali_pkg::DIST_W-1:0]  opb;
    logic [pali_pkg::DIST_W:0]    diff;
    logic                         ge;

    // Shared compare-subtract: root trial or shifted divisor
    always_comb
    begin
        if (op_reg == pali_pkg::UOP_SQRT)
        begin
            opa = {rem_reg[pali_pkg::DIST_W-3:0], num_reg[pali_pkg::RAD_W-1 -: 2]};
            opb = pali_pkg::DIST_W'({q_reg, 2'b01});
        end
        else
        begin
            opa = rem_reg;
            opb = den_reg;
        end
        diff = {1'b0, opa} - {1'b0, opb};
        ge   = ~diff[pali_pkg::DIST_W];
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= pali_pkg::UOP_SQRT;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.go)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                cnt_reg  <= (cmd.op == pali_pkg::UOP_SQRT) ?
                            pali_pkg::CNT_W'(pali_pkg::ROOT_W - 1) :
                            pali_pkg::CNT_W'(pali_pkg::F_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One result bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            num_reg <= num[pali_pkg::RAD_W-1:0];
            rem_reg <= (cmd.op == pali_pkg::UOP_SQRT) ? '0 : num[pali_pkg::DIST_W-1:0];
            den_reg <= pali_pkg::DIST_W'(den) << pali_pkg::PROGRESS_FRAC_BITS;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[pali_pkg::DIST_W-1:0] : opa;
            q_reg   <= {q_reg[pali_pkg::Q_W-2:0], ge};
            num_reg <= num_reg << 2;
            den_reg <= den_reg >> 1;
        end
    end

    assign stat.done   = done_reg;
    assign stat.result = q_reg;

endmodule

// ===== rtl/polyline_arc_length_interpolator_top.sv =====
// Top level of the polyline arc-length interpolator: point registers,
// sequencer, shared multiplier and result registers.
// Depends on pali_pkg and pali_root_div.

// An item is one transfer of progress (start high while busy is low); the
// result appears on pos_x, pos_y and segment_index for the single cycle that
// done is high, and must be taken then, since the block cannot be held off.
// The busy output falls in the cycle that done is high. Each item runs three
// 23-step square roots and one 17-step division in the bit-serial root/divide
// unit, plus up to two segment-search steps. Point registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while busy
// is low, and the block itself does not enforce this.
module polyline_arc_length_interpolator_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [pali_pkg::REG_IDX_W-1:0]            cfg_index,
    input  logic [pali_pkg::COORD_BITS-1:0]           cfg_data,
    input  logic                                      start,
    input  logic [pali_pkg::PROG_W-1:0]               progress,
    output logic                                      busy,
    output logic                                      done,
    output logic signed [pali_pkg::COORD_BITS-1:0]    pos_x,
    output logic signed [pali_pkg::COORD_BITS-1:0]    pos_y,
    output logic [pali_pkg::SEG_W-1:0]                segment_index
);

    localparam int CB  = pali_pkg::COORD_BITS;
    localparam int PFB = pali_pkg::PROGRESS_FRAC_BITS;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_DIFF      = 13'b0000000000010,
        ST_SQX       = 13'b0000000000100,
        ST_SQY       = 13'b0000000001000,
        ST_ROOT_GO   = 13'b0000000010000,
        ST_ROOT_WAIT = 13'b0000000100000,
        ST_DIST      = 13'b0000001000000,
        ST_SEARCH    = 13'b0000010000000,
        ST_DIV_GO    = 13'b0000100000000,
        ST_DIV_WAIT  = 13'b0001000000000,
        ST_MULX      = 13'b0010000000000,
        ST_MULY      = 13'b0100000000000,
        ST_OUT       = 13'b1000000000000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;

    logic signed [CB-1:0]                coord_reg [pali_pkg::NUM_REGS];

    // Control registers
    logic [pali_pkg::SEG_W-1:0]          seg_reg;
    logic                                done_reg;

    // Datapath registers
    logic [pali_pkg::PROG_W-1:0]         p_reg;
    logic [CB-1:0]                       ax_reg;
    logic [CB-1:0]                       ay_reg;
    logic signed [CB:0]                  sdx_reg;
    logic signed [CB:0]                  sdy_reg;
    logic [2*CB-1:0]                     sqx_reg;
    logic signed [pali_pkg::PROD_W-1:0]  prod_reg;
    logic [pali_pkg::LEN_W-1:0]          len_reg [3];
    logic [pali_pkg::TOTAL_W-1:0]        total_reg;
    logic [pali_pkg::TOTAL_W-1:0]        cum_reg;
    logic [pali_pkg::F_W-1:0]            f_reg;
    logic signed [CB-1:0]                pos_x_reg;
    logic signed [CB-1:0]                pos_y_reg;
    logic [pali_pkg::SEG_W-1:0]          seg_out_reg;

    // Combinational
    logic signed [CB-1:0]                sx, sy, ex, ey;
    logic signed [CB:0]                  dx_full, dy_full;
    logic [CB-1:0]                       ax_abs, ay_abs;
    logic signed [pali_pkg::MW-1:0]      mul_a, mul_b;
    logic                                mul_en;
    logic [pali_pkg::SQ_W-1:0]           sum_sq;
    logic [pali_pkg::RAD_W-1:0]          radicand;
    logic [pali_pkg::DIST_W-1:0]         covered_dist;
    logic [pali_pkg::TOTAL_W-1:0]        cum_len;
    logic                                advance;
    logic [pali_pkg::DIST_W-1:0]         rem_dist;
    logic [pali_pkg::LEN_W-1:0]          seg_len;
    logic [pali_pkg::PROG_W-1:0]         p_sat;
    logic [pali_pkg::F_W-1:0]            f_sat;
    logic                                accept;

    pali_pkg::unit_cmd_t                 unit_cmd;
    pali_pkg::unit_stat_t                unit_stat;
    logic [pali_pkg::NUM_W-1:0]          unit_num;

    // Round s + term / 2^PFB to the nearest pixel, ties upward
    function automatic logic [CB-1:0] round_pos(
        input logic signed [CB-1:0]                s,
        input logic signed [pali_pkg::VAL_W-1:0]   term
    );
        logic signed [pali_pkg::VAL_W-1:0] val;
        val = (pali_pkg::VAL_W'(s) <<< PFB) + term
              + (pali_pkg::VAL_W'(1) <<< (PFB - 1));
        return val[PFB +: CB];
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign p_sat  = (progress > pali_pkg::PROG_ONE) ? pali_pkg::PROG_ONE : progress;

    // Point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pali_pkg::NUM_REGS; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coord_reg[cfg_index] <= cfg_data;
        end
    end

    // Segment end points
    always_comb
    begin
        unique case (seg_reg)
            pali_pkg::SEG0:
            begin
                sx = coord_reg[0]; sy = coord_reg[1];
                ex = coord_reg[2]; ey = coord_reg[3];
            end
            pali_pkg::SEG1:
            begin
                sx = coord_reg[2]; sy = coord_reg[3];
                ex = coord_reg[4]; ey = coord_reg[5];
            end
            pali_pkg::SEG2:
            begin
                sx = coord_reg[4]; sy = coord_reg[5];
                ex = coord_reg[6]; ey = coord_reg[7];
            end
            default:
            begin
                sx = '0; sy = '0;
                ex = '0; ey = '0;
            end
        endcase
    end

    // Signed differences and magnitudes
    assign dx_full = (CB+1)'(ex) - (CB+1)'(sx);
    assign dy_full = (CB+1)'(ey) - (CB+1)'(sy);
    assign ax_abs  = dx_full[CB] ? CB'(-dx_full) : CB'(dx_full);
    assign ay_abs  = dy_full[CB] ? CB'(-dy_full) : CB'(dy_full);

    // Shared multiplier operands
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = $signed(pali_pkg::MW'(ax_reg));
                mul_b = $signed(pali_pkg::MW'(ax_reg));
            end
            ST_SQY:
            begin
                mul_a = $signed(pali_pkg::MW'(ay_reg));
                mul_b = $signed(pali_pkg::MW'(ay_reg));
            end
            ST_DIST:
            begin
                mul_a = $signed(pali_pkg::MW'(p_reg));
                mul_b = $signed(pali_pkg::MW'(total_reg));
            end
            ST_MULX:
            begin
                mul_a = pali_pkg::MW'(sdx_reg);
                mul_b = $signed(pali_pkg::MW'(f_reg));
            end
            ST_MULY:
            begin
                mul_a = pali_pkg::MW'(sdy_reg);
                mul_b = $signed(pali_pkg::MW'(f_reg));
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Radicand, covered distance, search step and division operand
    assign sum_sq       = pali_pkg::SQ_W'(sqx_reg) + pali_pkg::SQ_W'(prod_reg[2*CB-1:0]);
    assign radicand     = pali_pkg::RAD_W'(sum_sq) << (2 * pali_pkg::LEN_FRAC_BITS);
    assign covered_dist = prod_reg[pali_pkg::DIST_W-1:0];
    assign seg_len      = len_reg[seg_reg];
    assign cum_len      = cum_reg + pali_pkg::TOTAL_W'(seg_len);
    assign advance      = (seg_reg != pali_pkg::SEG2) &&
                          ((pali_pkg::DIST_W'(cum_len) << PFB) < covered_dist);
    assign rem_dist     = covered_dist - (pali_pkg::DIST_W'(cum_reg) << PFB);
    assign f_sat        = (unit_stat.result > pali_pkg::Q_W'(pali_pkg::PROG_ONE)) ?
                          pali_pkg::PROG_ONE : unit_stat.result[pali_pkg::F_W-1:0];

    // Root/divide unit commands
    always_comb
    begin
        unit_cmd.go = (state_reg == ST_ROOT_GO) || (state_reg == ST_DIV_GO);
        unit_cmd.op = (state_reg == ST_DIV_GO) ? pali_pkg::UOP_DIV : pali_pkg::UOP_SQRT;
        unit_num    = (state_reg == ST_DIV_GO) ? pali_pkg::NUM_W'(rem_dist) :
                                                 pali_pkg::NUM_W'(radicand);
    end

    pali_root_div u_root_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (unit_cmd),
        .num   (unit_num),
        .den   (seg_len),
        .stat  (unit_stat)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_SQX;
            ST_SQX:       state_next = ST_SQY;
            ST_SQY:       state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (unit_stat.done)
                begin
                    state_next = (seg_reg == pali_pkg::SEG2) ? ST_DIST : ST_DIFF;
                end
            end
            ST_DIST:      state_next = ST_SEARCH;
            ST_SEARCH:    if (!advance) state_next = ST_DIV_GO;
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (unit_stat.done) state_next = ST_MULX;
            ST_MULX:      state_next = ST_MULY;
            ST_MULY:      state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= pali_pkg::SEG0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_OUT);
            if (accept)
            begin
                seg_reg <= pali_pkg::SEG0;
            end
            else if (state_reg == ST_ROOT_WAIT && unit_stat.done)
            begin
                seg_reg <= (seg_reg == pali_pkg::SEG2) ? pali_pkg::SEG0 :
                           pali_pkg::SEG_W'(seg_reg + 1'b1);
            end
            else if (state_reg == ST_SEARCH && advance)
            begin
                seg_reg <= pali_pkg::SEG_W'(seg_reg + 1'b1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg     <= p_sat;
            total_reg <= '0;
        end
        if (state_reg == ST_DIFF || state_reg == ST_DIV_GO)
        begin
            ax_reg  <= ax_abs;
            ay_reg  <= ay_abs;
            sdx_reg <= dx_full;
            sdy_reg <= dy_full;
        end
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_SQY)
        begin
            sqx_reg <= prod_reg[2*CB-1:0];
        end
        if (state_reg == ST_ROOT_WAIT && unit_stat.done)
        begin
            len_reg[seg_reg] <= unit_stat.result[pali_pkg::LEN_W-1:0];
            total_reg        <= total_reg +
                                pali_pkg::TOTAL_W'(unit_stat.result[pali_pkg::LEN_W-1:0]);
        end
        if (state_reg == ST_DIST)
        begin
            cum_reg <= '0;
        end
        else if (state_reg == ST_SEARCH && advance)
        begin
            cum_reg <= cum_len;
        end
        if (state_reg == ST_DIV_WAIT && unit_stat.done)
        begin
            f_reg <= (seg_len == '0) ? '0 : f_sat;
        end
        if (state_reg == ST_MULY)
        begin
            pos_x_reg <= round_pos(sx, prod_reg[pali_pkg::VAL_W-1:0]);
        end
        if (state_reg == ST_OUT)
        begin
            pos_y_reg   <= round_pos(sy, prod_reg[pali_pkg::VAL_W-1:0]);
            seg_out_reg <= seg_reg;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign segment_index = seg_out_reg;

endmodule
